### rtl/tws_pkg.sv
// Shared sizes, codes and types of the timing wheel scheduler.
// Depends on nothing; every other file imports it.
package tws_pkg;

  localparam int NUM_TASKS   = 32;
  localparam int WHEEL_SLOTS = 64;
  localparam int TIME_BITS   = 32;

  localparam int TASK_W = 5;
  localparam int LINK_W = $clog2(NUM_TASKS + 1);
  localparam int OFF_W  = $clog2(WHEEL_SLOTS);
  localparam int SLOT_W = $clog2(WHEEL_SLOTS + 2);

  localparam logic [LINK_W-1:0] NONE_LINK  = LINK_W'(NUM_TASKS);
  localparam logic [SLOT_W-1:0] IMMED_SLOT = SLOT_W'(WHEEL_SLOTS);

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_NONE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_NEW   = 2'd0,
    ST_MOVED = 2'd1,
    ST_KEPT  = 2'd2
  } add_status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_UNL, S_APR, S_APP, S_EXE, S_HD, S_WALK, S_FIN
  } state_e;

  typedef struct packed {
    logic                 is_exec;
    logic [TASK_W-1:0]    task_id;
    logic                 delay_nz;
    logic [TIME_BITS-1:0] due;
    logic [TIME_BITS-1:0] now;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } req_chan_t;

  function automatic logic [OFF_W-1:0] wrap_add(input logic [OFF_W-1:0] a,
                                                input logic [OFF_W-1:0] b);
    logic [OFF_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (OFF_W+1)'(WHEEL_SLOTS)) begin
      s = s - (OFF_W+1)'(WHEEL_SLOTS);
    end
    return s[OFF_W-1:0];
  endfunction

  function automatic logic [OFF_W-1:0] clamp_diff(input logic [TIME_BITS-1:0] d);
    if (d > TIME_BITS'(WHEEL_SLOTS - 1)) begin
      return OFF_W'(WHEEL_SLOTS - 1);
    end
    return d[OFF_W-1:0];
  endfunction

endpackage

### rtl/tws_in_if.sv
// Input channel of the scheduler: valid, ready and one request word.
// Depends on tws_pkg.
interface tws_in_if import tws_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [TASK_W-1:0]    task_id;
  logic [TIME_BITS-1:0] delay_units;
  logic [TIME_BITS-1:0] now_time;

  modport source (output valid, req_type, task_id, delay_units, now_time, input ready);
  modport sink   (input valid, req_type, task_id, delay_units, now_time, output ready);
endinterface

### rtl/tws_out_if.sv
// Output channel of the scheduler: valid, ready and one result word.
// Depends on tws_pkg.
interface tws_out_if import tws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        result_kind;
  logic [TASK_W-1:0] out_task_id;
  logic [1:0]        add_status;
  logic              last;

  modport source (output valid, result_kind, out_task_id, add_status, last, input ready);
  modport sink   (input valid, result_kind, out_task_id, add_status, last, output ready);
endinterface

### rtl/tws_front.sv
// Front end: accepts request words, computes the due time and queues them.
// Depends on tws_pkg and tws_in_if; feeds tws_back.
module tws_front import tws_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  tws_in_if.sink         in_i,
  output req_chan_t      q_o,
  input  logic           pop_i
);

  req_t       fifo_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic       push;
  req_t       entry;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;

  always_comb begin
    entry.is_exec  = in_i.req_type;
    entry.task_id  = in_i.task_id;
    entry.delay_nz = (in_i.delay_units != '0);
    entry.due      = in_i.now_time + in_i.delay_units;
    entry.now      = in_i.now_time;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  assign q_o = '{valid: (cnt_q != 2'd0), req: fifo_q[rp_q]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= entry;
    end
  end

endmodule

### rtl/tws_back.sv
// Back end: keeps the task lists and slot memory, runs adds and drains.
// Depends on tws_pkg and tws_out_if; fed by tws_front.
module tws_back import tws_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  req_chan_t  q_i,
  output logic       pop_o,
  tws_out_if.source  out_o
);

  typedef struct packed {
    logic [LINK_W-1:0] head;
    logic [LINK_W-1:0] tail;
  } slot_t;

  state_e st_q, st_d;
  req_t   cur_q;

  logic                 reg_q   [NUM_TASKS];
  logic [TIME_BITS-1:0] due_q   [NUM_TASKS];
  logic [SLOT_W-1:0]    sidx_q  [NUM_TASKS];
  logic [LINK_W-1:0]    nxt_q   [NUM_TASKS];
  logic [LINK_W-1:0]    prv_q   [NUM_TASKS];

  slot_t             smem [WHEEL_SLOTS+1];
  logic              svld_q [WHEEL_SLOTS+1];
  slot_t             rd_q;
  logic              rd_vld_q;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  slot_t             wr_data;

  logic [TIME_BITS-1:0] last_time_q;
  logic [OFF_W-1:0]     last_off_q, end_off_q;
  logic [SLOT_W-1:0]    snew_q, slot_q;
  logic [SLOT_W-1:0]    rem_q;
  logic [LINK_W-1:0]    t_q;
  logic                 held_q;
  logic [TASK_W-1:0]    held_id_q;

  logic              out_vld_q;
  logic [1:0]        out_kind_q, out_st_q;
  logic [TASK_W-1:0] out_id_q;
  logic              out_last_q;

  logic              out_free;
  logic              out_set;
  logic [TASK_W-1:0] id;
  logic              id_ok, keep;
  logic [OFF_W-1:0]  el, snew_off;
  slot_t             cur_slot, unl_slot;
  logic [LINK_W-1:0] up, un, tl;
  logic [TASK_W-1:0] t_idx;
  logic              t_live;
  logic [SLOT_W-1:0] next_slot;

  assign out_free = !out_vld_q || out_o.ready;
  assign id       = cur_q.task_id;
  assign id_ok    = ({1'b0, id} < (TASK_W+1)'(NUM_TASKS));
  assign keep     = !id_ok || (reg_q[id] && (due_q[id] < cur_q.due));
  assign el       = clamp_diff(cur_q.now - last_time_q);
  assign snew_off = wrap_add(last_off_q, clamp_diff(cur_q.due - last_time_q));
  assign cur_slot = rd_vld_q ? rd_q : slot_t'({NONE_LINK, NONE_LINK});
  assign up       = prv_q[id];
  assign un       = nxt_q[id];
  assign tl       = cur_slot.tail;
  assign t_idx    = t_q[TASK_W-1:0];
  assign t_live   = (t_q < NONE_LINK);
  assign next_slot = (slot_q == IMMED_SLOT) ? SLOT_W'(last_off_q) :
                     SLOT_W'(wrap_add(slot_q[OFF_W-1:0], OFF_W'(1)));

  always_comb begin
    unl_slot = cur_slot;
    if (!(up < NONE_LINK)) begin
      unl_slot.head = un;
    end
    if (!(un < NONE_LINK)) begin
      unl_slot.tail = up;
    end
  end

  always_comb begin
    st_d    = st_q;
    pop_o   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = IMMED_SLOT;
    wr_en   = 1'b0;
    wr_addr = snew_q;
    wr_data = unl_slot;
    out_set = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (q_i.valid) begin
          pop_o = 1'b1;
          st_d  = q_i.req.is_exec ? S_EXE : S_ADD;
        end
      end
      S_ADD: begin
        if (keep) begin
          if (out_free) begin
            out_set = 1'b1;
            st_d    = S_IDLE;
          end
        end else if (reg_q[id]) begin
          rd_en   = 1'b1;
          rd_addr = sidx_q[id];
          st_d    = S_UNL;
        end else begin
          st_d = S_APR;
        end
      end
      S_UNL: begin
        wr_en   = 1'b1;
        wr_addr = sidx_q[id];
        st_d    = S_APR;
      end
      S_APR: begin
        rd_en   = 1'b1;
        rd_addr = snew_q;
        st_d    = S_APP;
      end
      S_APP: begin
        if (out_free) begin
          wr_en        = 1'b1;
          wr_data.head = (tl < NONE_LINK) ? cur_slot.head : LINK_W'(id);
          wr_data.tail = LINK_W'(id);
          out_set      = 1'b1;
          st_d         = S_IDLE;
        end
      end
      S_EXE: begin
        rd_en = 1'b1;
        st_d  = S_HD;
      end
      S_HD: begin
        st_d = S_WALK;
      end
      S_WALK: begin
        if (!t_live) begin
          if (rem_q != '0) begin
            rd_en   = 1'b1;
            rd_addr = next_slot;
            st_d    = S_HD;
          end else begin
            st_d = S_FIN;
          end
        end else if (held_q && out_free) begin
          out_set = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_set = 1'b1;
          st_d    = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      out_vld_q   <= 1'b0;
      held_q      <= 1'b0;
      last_time_q <= '0;
      last_off_q  <= '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        reg_q[i] <= 1'b0;
      end
      for (int i = 0; i <= WHEEL_SLOTS; i++) begin
        svld_q[i] <= 1'b0;
      end
    end else begin
      st_q      <= st_d;
      out_vld_q <= out_set || (out_vld_q && !out_o.ready);
      if (wr_en) begin
        svld_q[wr_addr] <= 1'b1;
      end
      case (st_q)
        S_APP: begin
          if (out_free) begin
            reg_q[id] <= 1'b1;
          end
        end
        S_HD: begin
          svld_q[slot_q] <= 1'b0;
        end
        S_WALK: begin
          if (t_live && (!held_q || out_free)) begin
            reg_q[t_idx] <= 1'b0;
            held_q       <= 1'b1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            held_q      <= 1'b0;
            last_time_q <= cur_q.now;
            last_off_q  <= end_off_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q     <= smem[rd_addr];
      rd_vld_q <= svld_q[rd_addr];
    end
    if (wr_en) begin
      smem[wr_addr] <= wr_data;
    end
    case (st_q)
      S_IDLE: begin
        cur_q <= q_i.req;
      end
      S_ADD: begin
        snew_q <= cur_q.delay_nz ? SLOT_W'(snew_off) : IMMED_SLOT;
        if (keep && out_free) begin
          out_kind_q <= KIND_ADD;
          out_id_q   <= id;
          out_st_q   <= ST_KEPT;
          out_last_q <= 1'b1;
        end
      end
      S_UNL: begin
        if (up < NONE_LINK) begin
          nxt_q[up[TASK_W-1:0]] <= un;
        end
        if (un < NONE_LINK) begin
          prv_q[un[TASK_W-1:0]] <= up;
        end
      end
      S_APP: begin
        if (out_free) begin
          due_q[id]  <= cur_q.due;
          sidx_q[id] <= snew_q;
          nxt_q[id]  <= NONE_LINK;
          prv_q[id]  <= tl;
          if (tl < NONE_LINK) begin
            nxt_q[tl[TASK_W-1:0]] <= LINK_W'(id);
          end
          out_kind_q <= KIND_ADD;
          out_id_q   <= id;
          out_st_q   <= reg_q[id] ? ST_MOVED : ST_NEW;
          out_last_q <= 1'b1;
        end
      end
      S_EXE: begin
        slot_q    <= IMMED_SLOT;
        rem_q     <= SLOT_W'(el) + SLOT_W'(1);
        end_off_q <= wrap_add(last_off_q, el);
      end
      S_HD: begin
        t_q <= cur_slot.head;
      end
      S_WALK: begin
        if (t_live) begin
          if (!held_q || out_free) begin
            held_id_q <= t_idx;
            t_q       <= nxt_q[t_idx];
            if (held_q) begin
              out_kind_q <= KIND_RUN;
              out_id_q   <= held_id_q;
              out_st_q   <= ST_NEW;
              out_last_q <= 1'b0;
            end
          end
        end else if (rem_q != '0) begin
          slot_q <= next_slot;
          rem_q  <= rem_q - SLOT_W'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_kind_q <= held_q ? KIND_RUN : KIND_NONE;
          out_id_q   <= held_q ? held_id_q : '0;
          out_st_q   <= ST_NEW;
          out_last_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.out_task_id = out_id_q;
  assign out_o.add_status  = out_st_q;
  assign out_o.last        = out_last_q;

endmodule

### rtl/timing_wheel_scheduler.sv
// Top level of the timing wheel scheduler: front end, request queue, back end.
// Depends on tws_pkg, tws_in_if, tws_out_if, tws_front and tws_back.
//
//   channel  direction  word
//   in_i     sink       req_type, task_id, delay_units, now_time
//   out_o    source     result_kind, out_task_id, add_status, last
//
// A kept add does not touch the slot memory; a new add reads and writes its
// new slot, and a moved add first unlinks the task from its old slot. Slot
// reads are registered. An exec drains the immediate list and each due slot.
// Reset clears all lists at once through per-slot valid bits; no sweep.
// A stalled output holds the back end; the two-word queue accepts until full.
module timing_wheel_scheduler import tws_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tws_in_if.sink    in_i,
  tws_out_if.source out_o
);

  req_chan_t q;
  logic      pop;

  tws_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .q_o    (q),
    .pop_i  (pop)
  );

  tws_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (q),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  a_add_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.result_kind == KIND_ADD |-> out_o.last)
    else $error("add result without last");

  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.result_kind == KIND_NONE |->
      out_o.last && out_o.out_task_id == '0 && out_o.add_status == ST_NEW)
    else $error("empty exec result malformed");

  a_run_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.result_kind == KIND_RUN |-> out_o.add_status == ST_NEW)
    else $error("run result carries add status");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q.valid)
    else $error("queue popped while empty");

endmodule
